### hdl/bdps_pkg.sv
`timescale 1ns / 1ps
// shared constants, payload types and arithmetic helpers for the debounce and pot smoother
package bdps_pkg;

    localparam int BUTTON_COUNT = 16;
    localparam int POT_COUNT    = 8;
    localparam int ADC_BITS     = 12;
    localparam int SEL_BITS     = 3;
    localparam int TIME_BITS    = 32;
    localparam int DELAY_BITS   = 16;
    localparam int MIDI_BITS    = 7;
    localparam int MIDI_MAX     = 127;
    localparam int ADC_MAX      = (1 << ADC_BITS) - 1;

    localparam logic [DELAY_BITS-1:0] DELAY_RESET = DELAY_BITS'(20);

    typedef logic [BUTTON_COUNT-1:0] button_vec_t;
    typedef logic [TIME_BITS-1:0]    time_t;
    typedef logic [DELAY_BITS-1:0]   delay_t;
    typedef logic [SEL_BITS-1:0]     pot_sel_t;
    typedef logic [ADC_BITS-1:0]     adc_t;
    typedef logic [MIDI_BITS-1:0]    midi_t;

    typedef struct packed {
        time_t       now_ms;
        button_vec_t raw_buttons;
        pot_sel_t    pot_select;
        adc_t        pot_sample;
    } item_t;

    typedef struct packed {
        button_vec_t stable_buttons;
        pot_sel_t    pot_index;
        adc_t        pot_filtered;
        midi_t       pot_midi;
    } result_t;

    // floor((3 * prev + sample) / 4)
    function automatic adc_t smooth(input adc_t prev, input adc_t sample);
        logic [ADC_BITS+1:0] acc;
        acc = ({2'b00, prev} << 1) + {2'b00, prev} + {2'b00, sample};
        return acc[ADC_BITS+1:2];
    endfunction

    // floor(filt * 127 / (2^ADC_BITS - 1)) by folding the high part back in
    function automatic midi_t midi_scale(input adc_t filt);
        logic [ADC_BITS+MIDI_BITS-1:0] prod;
        logic [MIDI_BITS-1:0]          q0;
        logic [ADC_BITS:0]             rem;
        prod = {{MIDI_BITS{1'b0}}, filt} * (ADC_BITS+MIDI_BITS)'(MIDI_MAX);
        q0   = prod[ADC_BITS+MIDI_BITS-1:ADC_BITS];
        rem  = {1'b0, prod[ADC_BITS-1:0]} + (ADC_BITS+1)'(q0);
        if (rem >= (ADC_BITS+1)'(ADC_MAX))
        begin
            return q0 + MIDI_BITS'(1);
        end
        return q0;
    endfunction

endpackage

### hdl/bdps_item_if.sv
`timescale 1ns / 1ps
// input item channel: valid, ready and one sensor scan item
interface bdps_item_if
    import bdps_pkg::*;
    ();
    logic  valid;
    logic  ready;
    item_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/bdps_result_if.sv
`timescale 1ns / 1ps
// result channel: valid, ready and one debounced and smoothed result
interface bdps_result_if
    import bdps_pkg::*;
    ();
    logic    valid;
    logic    ready;
    result_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

### hdl/bdps_cfg_if.sv
`timescale 1ns / 1ps
// configuration write channel carrying the debounce delay
interface bdps_cfg_if
    import bdps_pkg::*;
    ();
    logic   valid;
    logic   ready;
    delay_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hdl/button_debounce_and_pot_smoother.sv
`timescale 1ns / 1ps
// top level of the button debouncer and pot smoother
//
//  channel   dir  handshake        payload
//  item      in   valid / ready    now_ms, raw_buttons, pot_select, pot_sample
//  result    out  valid / ready    stable_buttons, pot_index, pot_filtered, pot_midi
//  cfg       in   valid / ready    debounce delay in ms
//
// one item per cycle while the skid stage is empty; results are registered on transfer
// state for buttons and pots updates in the cycle of the item transfer
// a stalled result is held while one more item is taken into the skid stage
// rst_n clears all button state, pot primed flags and sets the delay to 20 ms
// cfg is always ready
module button_debounce_and_pot_smoother
    import bdps_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    bdps_item_if.sink     item,
    bdps_result_if.source result,
    bdps_cfg_if.sink      cfg
);

    delay_t      delay_reg;
    logic        accept;
    logic        buf_ready;
    button_vec_t stable_next;
    adc_t        pot_filtered;
    midi_t       pot_midi;
    result_t     res;

    assign cfg.ready  = 1'b1;
    assign item.ready = buf_ready;
    assign accept     = item.valid && buf_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_reg <= DELAY_RESET;
        end
        else if (cfg.valid)
        begin
            delay_reg <= cfg.data;
        end
    end

    bdps_debounce u_debounce (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .now_ms      (item.payload.now_ms),
        .raw_buttons (item.payload.raw_buttons),
        .delay_ms    (delay_reg),
        .stable_next (stable_next)
    );

    bdps_pot u_pot (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .pot_select   (item.payload.pot_select),
        .pot_sample   (item.payload.pot_sample),
        .pot_filtered (pot_filtered),
        .pot_midi     (pot_midi)
    );

    always_comb
    begin
        res.stable_buttons = stable_next;
        res.pot_index      = item.payload.pot_select;
        res.pot_filtered   = pot_filtered;
        res.pot_midi       = pot_midi;
    end

    bdps_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (item.valid),
        .push_ready (buf_ready),
        .push_data  (res),
        .result     (result)
    );

endmodule

### hdl/bdps_debounce.sv
`timescale 1ns / 1ps
// per-button time based debouncer with change time registers
module bdps_debounce
    import bdps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        accept,
    input  time_t       now_ms,
    input  button_vec_t raw_buttons,
    input  delay_t      delay_ms,
    output button_vec_t stable_next
);

    button_vec_t stable_reg;
    button_vec_t prev_raw_reg;
    time_t       change_time_reg [BUTTON_COUNT];
    time_t       change_time_next [BUTTON_COUNT];
    time_t       elapsed [BUTTON_COUNT];

    always_comb
    begin
        for (int i = 0; i < BUTTON_COUNT; i++)
        begin
            change_time_next[i] = (raw_buttons[i] != prev_raw_reg[i]) ? now_ms
                                                                      : change_time_reg[i];
            elapsed[i]          = now_ms - change_time_next[i];
            stable_next[i]      = (elapsed[i] > TIME_BITS'(delay_ms)) ? raw_buttons[i]
                                                                      : stable_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stable_reg   <= '0;
            prev_raw_reg <= '0;
            for (int i = 0; i < BUTTON_COUNT; i++)
            begin
                change_time_reg[i] <= '0;
            end
        end
        else if (accept)
        begin
            stable_reg      <= stable_next;
            prev_raw_reg    <= raw_buttons;
            change_time_reg <= change_time_next;
        end
    end

    // on button 0, a raw level equal to the last one never starts a new change time
    a_hold_time : assert property (@(posedge clk) disable iff (!rst_n)
        accept && (raw_buttons[0] == prev_raw_reg[0]) |=>
            change_time_reg[0] == $past(change_time_reg[0]))
        else $error("change time moved without a raw change");

    // debounced levels only move on a transfer
    a_stable_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(stable_reg))
        else $error("stable levels changed without a transfer");

endmodule

### hdl/bdps_pot.sv
`timescale 1ns / 1ps
// per-pot first order smoothing filter and 0..127 scaling
module bdps_pot
    import bdps_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     accept,
    input  pot_sel_t pot_select,
    input  adc_t     pot_sample,
    output adc_t     pot_filtered,
    output midi_t    pot_midi
);

    adc_t                 smoothed_reg [POT_COUNT];
    logic [POT_COUNT-1:0] primed_reg;
    logic                 in_range;
    adc_t                 filt_new;

    always_comb
    begin
        in_range = ({1'b0, pot_select} < (SEL_BITS+1)'(POT_COUNT));
        filt_new = primed_reg[pot_select] ? smooth(smoothed_reg[pot_select], pot_sample)
                                          : pot_sample;
        pot_filtered = in_range ? filt_new : '0;
        pot_midi     = in_range ? midi_scale(filt_new) : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            primed_reg <= '0;
        end
        else if (accept && in_range)
        begin
            primed_reg[pot_select] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && in_range)
        begin
            smoothed_reg[pot_select] <= filt_new;
        end
    end

endmodule

### hdl/bdps_out_buf.sv
`timescale 1ns / 1ps
// result register with skid stage so one more input is taken under output stall
module bdps_out_buf
    import bdps_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  result_t push_data,
    bdps_result_if.source result
);

    logic    out_valid_reg;
    logic    out_valid_next;
    result_t out_data_reg;
    result_t out_data_next;
    logic    skid_valid_reg;
    logic    skid_valid_next;
    result_t skid_data_reg;
    result_t skid_data_next;
    logic    push;
    logic    pop;

    assign push_ready     = !skid_valid_reg;
    assign push           = push_valid && push_ready;
    assign pop            = out_valid_reg && result.ready;
    assign result.valid   = out_valid_reg;
    assign result.payload = out_data_reg;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (skid_valid_reg)
        begin
            if (pop)
            begin
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || pop)
        begin
            out_valid_next = push;
            out_data_next  = push ? push_data : out_data_reg;
        end
        else if (push)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    a_skid_behind_out : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid stage full while output register empty");

    a_stall_to_skid : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !pop && push |=> skid_valid_reg)
        else $error("transfer under stall not caught by skid stage");

    a_skid_drains : assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && pop |=> !skid_valid_reg && out_data_reg == $past(skid_data_reg))
        else $error("skid stage did not move into output register");

endmodule
